[rtl/ept_pkg.sv]
// shared constants and the wrap-corrected difference function
// for the encoder position and speed tracker; no dependencies
package ept_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned SCALE_W = 20;
    localparam int unsigned PROD_W  = DATA_W + SCALE_W;

    // microseconds per second
    localparam logic [SCALE_W-1:0] US_PER_S = 20'd1000000;

    // configuration register indexes
    localparam logic REG_COUNT_PERIOD = 1'b0;
    localparam logic REG_TIME_PERIOD  = 1'b1;

    localparam logic [DATA_W-1:0] COUNT_PERIOD_RST = 32'd65535;
    localparam logic [DATA_W-1:0] TIME_PERIOD_RST  = 32'hFFFF_FFFF;

    // input kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ZERO   = 1'b1;

    localparam logic [DATA_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SPEED_MIN = 32'h8000_0000;

    // difference of two counter readings, corrected by period + 1 when its
    // magnitude reaches half the period or more
    function automatic logic [DATA_W-1:0] wrap_diff(
        input logic [DATA_W-1:0] period,
        input logic [DATA_W-1:0] before_val,
        input logic [DATA_W-1:0] after_val
    );
        logic [DATA_W-1:0]   pm1;
        logic [DATA_W-1:0]   raw;
        logic signed [33:0]  half;
        logic signed [33:0]  modulus;
        logic signed [33:0]  d;
        logic signed [33:0]  r;
        pm1     = period - 32'd1;
        raw     = after_val - before_val;
        half    = signed'({3'b000, pm1[31:1]}) + 34'sd1;
        modulus = signed'({2'b00, period}) + 34'sd1;
        d       = signed'({{2{raw[31]}}, raw});
        if (d >= half) begin
            r = d - modulus;
        end else if (d <= -half) begin
            r = d + modulus;
        end else begin
            r = d;
        end
        return r[DATA_W-1:0];
    endfunction

endpackage

[rtl/ept_div.sv]
// restoring divider, one quotient bit per cycle
// unsigned operands; uses no package
module ept_div #(
    parameter int unsigned NUM_W = 52,
    parameter int unsigned DEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_sub;
    logic             qbit;

    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign qbit      = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= numer;
                rem_reg  <= '0;
                den_reg  <= denom;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[NUM_W-2:0], qbit};
                rem_reg <= qbit ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

[rtl/encoder_position_speed_tracker.sv]
// encoder position and speed tracker, top level
// depends on ept_pkg and ept_div
//
// s_ channel: one transfer per sample; s_tuser carries kind (sample or zero),
// s_tdata carries count_sample (bits 31:0) and time_sample (bits 63:32).
// m_ channel: one result transfer per input transfer, in order.
// cfg channel: writes count_period (index 0) or time_period (index 1);
// write only while no sample is in flight. cfg_ready is always high.
// A sample with a non-zero time delta passes through two wrap-correction
// steps, the multiply by 10^6, the divider start, the serial divider (one
// step per bit of the 52-bit quotient), its completion and the output load.
// A zero time delta goes from the wrap correction straight to the output
// load, and a zero event straight to it. s_tready comes back with the
// result, so no new sample is taken until the last one's result is loaded.
// s_tready is low while a sample is being worked on; one result may wait in
// the output register while the next sample is taken in, and a stalled
// receiver only holds the sequencer at its final step.
// Reset clears position, speed and last count, sets last time to 1 and
// loads the period registers with their defaults.
module encoder_position_speed_tracker #(
    parameter int unsigned TIMER_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tuser: kind
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [0:0]   s_tuser,
    // s_tdata: count_sample, time_sample
    input  logic [63:0]  s_tdata,
    // m_tdata: position, speed, count_delta, time_delta
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int unsigned DW = ept_pkg::DATA_W;
    localparam int unsigned PW = ept_pkg::PROD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_TIME,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [DW-1:0]          count_period_reg;
    logic [DW-1:0]          time_period_reg;
    logic [DW-1:0]          last_count_reg;
    logic [TIMER_WIDTH-1:0] last_time_reg;
    logic [DW-1:0]          position_reg;
    logic [DW-1:0]          speed_reg;
    logic [DW-1:0]          cnow_reg;
    logic [TIMER_WIDTH-1:0] tnow_reg;
    logic [DW-1:0]          dx_reg;
    logic [DW-1:0]          dt_reg;
    logic [DW-1:0]          absx_reg;
    logic [DW-1:0]          absdt_reg;
    logic                   neg_reg;
    logic [PW-1:0]          prod_reg;
    logic                   m_tvalid_reg;
    logic [127:0]           m_tdata_reg;

    logic [DW-1:0]          dx_next;
    logic [DW-1:0]          dt_next;
    logic [PW-1:0]          prod_next;
    logic [DW-1:0]          speed_next;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [PW-1:0]          div_quot;
    logic                   out_free;
    logic                   in_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign dx_next = ept_pkg::wrap_diff(count_period_reg, last_count_reg, cnow_reg);
    assign dt_next = ept_pkg::wrap_diff(time_period_reg, DW'(last_time_reg), DW'(tnow_reg));
    assign prod_next = absx_reg * ept_pkg::US_PER_S;

    // truncated quotient magnitude, signed and saturated
    always_comb begin
        if (neg_reg) begin
            if (div_quot > PW'(ept_pkg::SPEED_MIN)) begin
                speed_next = ept_pkg::SPEED_MIN;
            end else begin
                speed_next = DW'(-div_quot);
            end
        end else begin
            if (div_quot > PW'(ept_pkg::SPEED_MAX)) begin
                speed_next = ept_pkg::SPEED_MAX;
            end else begin
                speed_next = div_quot[DW-1:0];
            end
        end
    end

    assign div_start = (state_reg == ST_START);

    ept_div #(
        .NUM_W (PW),
        .DEN_W (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (prod_reg),
        .denom   (absdt_reg),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            count_period_reg <= ept_pkg::COUNT_PERIOD_RST;
            time_period_reg  <= ept_pkg::TIME_PERIOD_RST;
            last_count_reg   <= '0;
            last_time_reg    <= TIMER_WIDTH'(1);
            position_reg     <= '0;
            speed_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    ept_pkg::REG_COUNT_PERIOD: count_period_reg <= cfg_data;
                    ept_pkg::REG_TIME_PERIOD:  time_period_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (s_tuser[0] == ept_pkg::KIND_ZERO) begin
                            last_count_reg <= '0;
                            last_time_reg  <= TIMER_WIDTH'(1);
                            position_reg   <= '0;
                            speed_reg      <= '0;
                            dx_reg         <= '0;
                            dt_reg         <= '0;
                            state_reg      <= ST_OUT;
                        end else begin
                            cnow_reg  <= s_tdata[31:0];
                            tnow_reg  <= s_tdata[32 +: TIMER_WIDTH];
                            state_reg <= ST_COUNT;
                        end
                    end
                end
                ST_COUNT: begin
                    dx_reg         <= dx_next;
                    absx_reg       <= dx_next[DW-1] ? -dx_next : dx_next;
                    last_count_reg <= cnow_reg;
                    position_reg   <= position_reg + dx_next;
                    state_reg      <= ST_TIME;
                end
                ST_TIME: begin
                    dt_reg        <= dt_next;
                    absdt_reg     <= dt_next[DW-1] ? -dt_next : dt_next;
                    neg_reg       <= dx_reg[DW-1] ^ dt_next[DW-1];
                    last_time_reg <= tnow_reg;
                    // zero time delta keeps the previous speed
                    state_reg     <= (dt_next == '0) ? ST_OUT : ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_START;
                end
                ST_START: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        speed_reg <= speed_next;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tdata_reg <= {dt_reg, dx_reg, speed_reg, position_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // a transfer in keeps the input side closed on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("input accepted while a sample was in flight");

    // the divider only runs while the sequencer waits for it
    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside its wait state");

    // a finished division always lands in the divide wait state
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV) && $past(div_busy))
        else $error("unexpected divider completion");

endmodule
